// File: sv/iirms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirms_pkg
// Types, register indexes and arithmetic constants of the IIR moving-sum core.
// ----------------------------------------------------------------------------
package iirms_pkg;

  localparam int MAX_ORDER_DEF = 3;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int FILT_W   = 24;
  localparam int SUM_W    = 26;
  localparam int ORDER_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam int PBX_W  = COEF_W + SAMPLE_W;
  localparam int PAF_W  = COEF_W + FILT_W;
  localparam int TERM_W = PAF_W + 1;
  localparam int ACC_W  = TERM_W + 3;
  localparam int FRAC_W = 14;

  localparam int signed SAT_HI = 8388607;
  localparam int signed SAT_LO = -8388608;
  localparam int signed ROUND_HALF = 8192;
  localparam int signed COEF_ONE = 16384;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       sequence_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] window_sum;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic tap_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/iirms_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirms_cell
// One history cell: holds x[n-k] and f[n-k], forms its tap term and hands its
// history to the next cell on each request.
// ----------------------------------------------------------------------------
module iirms_cell
  import iirms_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic signed [SAMPLE_W-1:0] x_i,
  input  wire logic signed [FILT_W-1:0]   f_i,
  input  wire logic signed [COEF_W-1:0]   coef_b_i,
  input  wire logic signed [COEF_W-1:0]   coef_a_i,
  output logic signed [SAMPLE_W-1:0] x_pass_o,
  output logic signed [FILT_W-1:0]   f_pass_o,
  output logic signed [TERM_W-1:0]   term_o,
  output logic signed [FILT_W-1:0]   win_o
);

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [FILT_W-1:0]   f_q;
  logic signed [PBX_W-1:0]    pbx;
  logic signed [PAF_W-1:0]    paf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      f_q <= '0;
    end else if (ctrl_i.shift) begin
      x_q <= x_i;
      f_q <= f_i;
    end
  end

  // history reads as zero at a sequence start
  assign x_pass_o = ctrl_i.clear ? '0 : x_q;
  assign f_pass_o = ctrl_i.clear ? '0 : f_q;

  assign pbx = coef_b_i * x_pass_o;
  assign paf = coef_a_i * f_pass_o;

  assign term_o = ctrl_i.tap_en ? (TERM_W'(pbx) - TERM_W'(paf)) : '0;
  assign win_o  = ctrl_i.tap_en ? f_pass_o : '0;

endmodule
`default_nettype wire

// File: sv/iir_filter_moving_sum_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iir_filter_moving_sum_core
// Direct-form IIR filter (order 0..MAX_ORDER) followed by a moving sum.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while no result is stalled, and its
// result is in the output register in the cycle after the request; the throughput of one item per
// cycle is set by the feedback path from the first cell's stored f[n-1]
// through the a1 multiplier, the accumulator, rounding and saturation back
// into the cell chain. A stalled result holds while the next sample is taken
// as soon as the result leaves. Coefficients are signed Q3.14, the filtered
// value is rounded half up and clipped to 24 bits, and sequence_start clears
// all history before its own sample.
// ----------------------------------------------------------------------------
module iir_filter_moving_sum_core
  import iirms_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire in_item_t                in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output out_item_t                    out_data_o
);

  logic [ORDER_W-1:0]        order_q;
  logic signed [COEF_W-1:0]  coef_b_q [MAX_ORDER+1];
  logic signed [COEF_W-1:0]  coef_a_q [MAX_ORDER+1];
  logic [ORDER_W-1:0]        ord_eff;

  logic                      in_acc;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic signed [SAMPLE_W-1:0] x_link [MAX_ORDER+1];
  logic signed [FILT_W-1:0]   f_link [MAX_ORDER+1];
  logic signed [TERM_W-1:0]   term   [MAX_ORDER+1];
  logic signed [FILT_W-1:0]   win    [MAX_ORDER+1];
  cell_ctrl_t                 ctrl   [MAX_ORDER+1];

  logic signed [PBX_W-1:0]   pb0;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   f_full;
  logic signed [FILT_W-1:0]  f_new;
  logic                      sat;
  logic signed [SUM_W-1:0]   sum;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        coef_b_q[k] <= (k == 0) ? COEF_W'(COEF_ONE) : '0;
        coef_a_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_ORDER) begin
        order_q <= cfg_data_i[ORDER_W-1:0];
      end
      for (int k = 0; k <= MAX_ORDER; k++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_B0 + k)) begin
          coef_b_q[k] <= cfg_data_i;
        end
      end
      for (int k = 1; k <= MAX_ORDER; k++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_A1 + k - 1)) begin
          coef_a_q[k] <= cfg_data_i;
        end
      end
    end
  end

  assign ord_eff = (order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_q;

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // cell chain
  assign x_link[0] = in_data_i.sample_in;
  assign f_link[0] = f_new;
  assign term[0]   = '0;
  assign win[0]    = '0;
  assign ctrl[0]   = '0;

  for (genvar k = 1; k <= MAX_ORDER; k++) begin : g_cell
    assign ctrl[k].shift  = in_acc;
    assign ctrl[k].clear  = in_data_i.sequence_start;
    assign ctrl[k].tap_en = (ord_eff >= ORDER_W'(k));

    iirms_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[k]),
      .x_i      (x_link[k-1]),
      .f_i      (f_link[k-1]),
      .coef_b_i (coef_b_q[k]),
      .coef_a_i (coef_a_q[k]),
      .x_pass_o (x_link[k]),
      .f_pass_o (f_link[k]),
      .term_o   (term[k]),
      .win_o    (win[k])
    );
  end

  // accumulate, round, saturate, window
  assign pb0 = coef_b_q[0] * in_data_i.sample_in;

  always_comb begin
    acc = ACC_W'(pb0);
    sum = '0;
    for (int k = 1; k <= MAX_ORDER; k++) begin
      acc = acc + ACC_W'(term[k]);
    end
    f_full = (acc + ACC_W'(ROUND_HALF)) >>> FRAC_W;
    if (f_full > ACC_W'(SAT_HI)) begin
      f_new = FILT_W'(SAT_HI);
      sat   = 1'b1;
    end else if (f_full < ACC_W'(SAT_LO)) begin
      f_new = FILT_W'(SAT_LO);
      sat   = 1'b1;
    end else begin
      f_new = f_full[FILT_W-1:0];
      sat   = 1'b0;
    end
    sum = SUM_W'(f_new);
    for (int k = 1; k <= MAX_ORDER; k++) begin
      sum = sum + SUM_W'(win[k]);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.window_sum <= sum;
      out_q.saturated  <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted request produced no result");

  a_start_sum_is_f: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.sequence_start |=>
      (in_data_i.sequence_start || out_q.window_sum == SUM_W'(f_link[1])))
    else $error("window sum after sequence start differs from filtered value");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.saturated && !in_data_i.sequence_start |->
      (f_link[1] == FILT_W'(SAT_HI) || f_link[1] == FILT_W'(SAT_LO)))
    else $error("saturation flag without clipped filtered value");
`endif

endmodule
`default_nettype wire

// File: verif/iirms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirms_checker
// Prediction and result checking for the IIR moving-sum core.
// ----------------------------------------------------------------------------
// Follows the register writes and the accepted samples, and works out the
// expected window sum and clip flag for every request. Each delivered result
// is compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module iirms_checker
  import iirms_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  input  wire                  in_valid_i,
  input  wire                  in_ready_i,
  input  in_item_t             in_data_i,
  input  wire                  out_valid_i,
  input  wire                  out_ready_i,
  input  out_item_t            out_data_i,
  output int                   fail_count_o,
  output int                   waiting_o,
  output int                   checked_o,
  output int                   clipped_o
);

  logic        [ORDER_W-1:0]  order_q;
  logic signed [COEF_W-1:0]   num_tap [0:MAX_ORDER_DEF];
  logic signed [COEF_W-1:0]   den_tap [1:MAX_ORDER_DEF];
  logic signed [SAMPLE_W-1:0] x_hist  [0:MAX_ORDER_DEF-1];
  logic signed [FILT_W-1:0]   f_hist  [0:MAX_ORDER_DEF];
  out_item_t                  window_q [$];

  task automatic clear_history();
    for (int k = 0; k < MAX_ORDER_DEF; k++) x_hist[k] = '0;
    for (int k = 0; k <= MAX_ORDER_DEF; k++) f_hist[k] = '0;
  endtask

  // one step of the difference equation, then the moving sum
  task automatic filter_sample(input in_item_t req, output out_item_t res);
    int     ord;
    longint acc;
    longint filt;
    longint win;
    logic   clip;
    ord = (int'(order_q) > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(order_q);
    if (req.sequence_start) clear_history();
    acc = longint'(num_tap[0]) * longint'(req.sample_in);
    for (int k = 1; k <= ord; k++) begin
      acc += longint'(num_tap[k]) * longint'(x_hist[k-1]);
      acc -= longint'(den_tap[k]) * longint'(f_hist[k-1]);
    end
    // round half up, then clip to the filter width
    filt = (acc + ROUND_HALF) >>> FRAC_W;
    clip = 1'b0;
    if (filt > SAT_HI) begin
      filt = SAT_HI;
      clip = 1'b1;
    end else if (filt < SAT_LO) begin
      filt = SAT_LO;
      clip = 1'b1;
    end
    win = filt;
    for (int k = 0; k < ord; k++) win += longint'(f_hist[k]);
    for (int k = MAX_ORDER_DEF - 1; k > 0; k--) x_hist[k] = x_hist[k-1];
    x_hist[0] = req.sample_in;
    for (int k = MAX_ORDER_DEF; k > 0; k--) f_hist[k] = f_hist[k-1];
    f_hist[0] = filt[FILT_W-1:0];
    res.window_sum = win[SUM_W-1:0];
    res.saturated  = clip;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      order_q    = '0;
      num_tap[0] = COEF_W'(COEF_ONE);
      for (int k = 1; k <= MAX_ORDER_DEF; k++) begin
        num_tap[k] = '0;
        den_tap[k] = '0;
      end
      clear_history();
      window_q.delete();
      fail_count_o = 0;
      waiting_o    = 0;
      checked_o    = 0;
      clipped_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_ORDER) begin
          order_q = cfg_data_i[ORDER_W-1:0];
        end else if (cfg_index_i < REG_A1) begin
          num_tap[cfg_index_i - REG_B0] = cfg_data_i;
        end else begin
          den_tap[cfg_index_i - REG_A1 + 1] = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        filter_sample(in_data_i, want);
        window_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (window_q.size() == 0) begin
          $error("result with no request waiting: window_sum %0d saturated %0d",
                 got.window_sum, got.saturated);
          fail_count_o++;
        end else begin
          want = window_q.pop_front();
          if (got.window_sum !== want.window_sum) begin
            $error("window_sum: expected %0d, actual %0d", want.window_sum, got.window_sum);
            fail_count_o++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
            fail_count_o++;
          end
          checked_o++;
          if (want.saturated) clipped_o++;
        end
      end
      waiting_o = window_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the IIR moving-sum core.
// ----------------------------------------------------------------------------
// A short directed run covers sample extremes, rounding ties, saturation both
// ways, full-scale window sums and an order change inside a sequence. Random
// filter settings and sample streams follow, under three idle patterns on the
// sample and result channels. The checker beside the core does the checking.
// ----------------------------------------------------------------------------
module testbench
  import iirms_pkg::*;
();

  localparam int PHASE_ITEMS = 630;
  localparam logic [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_ready;
  logic                  in_ready;
  logic                  out_valid;
  out_item_t             out_data;

  int fail_count;
  int waiting;
  int checked;
  int clipped;
  int send_idle_pct = 19;
  int recv_idle_pct = 46;
  int samples_sent  = 0;
  int starts_sent   = 0;
  int settings_used = 0;

  logic [ORDER_W-1:0] order_set;
  logic [COEF_W-1:0]  num_set [0:3];
  logic [COEF_W-1:0]  den_set [1:3];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  iir_filter_moving_sum_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  iirms_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .waiting_o    (waiting),
    .checked_o    (checked),
    .clipped_o    (clipped)
  );

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // leaves cfg_valid high so back-to-back writes do not glitch it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_setting();
    write_reg(REG_ORDER, CFG_DATA_W'(order_set));
    for (int k = 0; k < 4; k++) write_reg(REG_B0 + CFG_IDX_W'(k), num_set[k]);
    for (int k = 1; k < 4; k++) write_reg(REG_A1 + CFG_IDX_W'(k - 1), den_set[k]);
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // history is kept, so the new order acts on the stored values
  task automatic change_order(input logic [ORDER_W-1:0] ord);
    order_set = ord;
    write_reg(REG_ORDER, CFG_DATA_W'(order_set));
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{sample_in: value, sequence_start: start};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
    if (start) starts_sent++;
  endtask

  // hold off requests until every result is back, then let the pipe settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(5))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      3:       return COEF_W'($urandom_range(8191)) - COEF_W'(4096);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'($urandom_range(127)) - SAMPLE_W'(64);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int   phase_count;
    int   blk_len;
    int   pause_at;
    logic fresh;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset setting: order zero, unity gain
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_W'(-1), 1'b0);
    send_sample(SAMPLE_W'(1), 1'b0);

    // half gain puts every odd sample on a rounding tie
    wait_idle();
    order_set = '0;
    num_set   = '{COEF_W'(COEF_ONE / 2), '0, '0, '0};
    den_set   = '{'0, '0, '0};
    apply_setting();
    send_sample(SAMPLE_W'(1), 1'b1);
    send_sample(SAMPLE_W'(-1), 1'b0);
    send_sample(SAMPLE_W'(3), 1'b0);
    send_sample(SAMPLE_W'(-3), 1'b0);

    // sign-alternating feedback clips high and low
    wait_idle();
    order_set = ORDER_W'(1);
    num_set   = '{COEF_MAX, '0, '0, '0};
    den_set   = '{COEF_MAX, '0, '0};
    apply_setting();
    for (int k = 0; k < 5; k++) send_sample(SAMPLE_MAX, k == 0);

    // growing feedback at full order drives the window toward its top
    wait_idle();
    order_set = ORDER_W'(3);
    num_set   = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
    den_set   = '{COEF_MIN, COEF_MIN, COEF_MIN};
    apply_setting();
    for (int k = 0; k < 5; k++) send_sample(SAMPLE_MAX, k == 0);

    wait_idle();
    change_order(ORDER_W'(2));
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);

    wait_idle();
    order_set = ORDER_W'(3);
    num_set   = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
    apply_setting();
    for (int k = 0; k < 4; k++) send_sample(SAMPLE_MAX, k == 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 19 : 0;
      phase_count   = 0;
      while (phase_count < PHASE_ITEMS) begin
        wait_idle();
        fresh = ($urandom_range(3) != 0);
        if (fresh) begin
          order_set = ORDER_W'($urandom_range(3));
          for (int k = 0; k < 4; k++) num_set[k] = random_coef();
          for (int k = 1; k < 4; k++) den_set[k] = random_coef();
          apply_setting();
        end else begin
          change_order(ORDER_W'($urandom_range(3)));
        end
        blk_len  = $urandom_range(80, 10);
        pause_at = $urandom_range(2 * blk_len);
        for (int k = 0; k < blk_len; k++) begin
          if (k == pause_at) wait_idle();
          send_sample(random_sample(), (fresh && k == 0) || ($urandom_range(49) == 0));
        end
        phase_count += blk_len;
      end
    end

    wait_idle();
    $display("covered %0d samples with %0d sequence starts under %0d filter settings",
             samples_sent, starts_sent, settings_used);
    $display("%0d results checked, %0d of them clipped to 24 bits", checked, clipped);
    if (fail_count == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
